// ===== rtl/core/chunked_body_decoder_macros.svh =====
// Assertion macros used by the checker file of the chunked body decoder.
`ifndef CHUNKED_BODY_DECODER_MACROS_SVH
`define CHUNKED_BODY_DECODER_MACROS_SVH

// Checked on every rising edge while reset is released.
`define CBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge after a reset cycle.
`define CBD_ASSERT_AFTER_RESET(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (!$past(rst_n) |-> (prop))) \
    else $error(msg);

`endif

// ===== rtl/core/cbd_pkg.sv =====
`default_nettype none

package cbd_pkg;

  localparam int LEN_BITS_DEF  = 32;
  localparam int TOKEN_DEPTH   = 4;
  localparam int RESULT_DEPTH  = 2;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Byte classes produced by the front end.
  localparam logic [1:0] CLS_HEX   = 2'd0;
  localparam logic [1:0] CLS_CR    = 2'd1;
  localparam logic [1:0] CLS_LF    = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       body_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
  } out_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       body_start;
    logic [1:0] cls;
    logic [3:0] hex_val;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/cbd_fifo.sv =====
`default_nettype none

module cbd_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  item_t wr_data,
  output logic  full,
  input  wire   pop,
  output item_t rd_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbd_front.sv =====
`default_nettype none

module cbd_front (
  input  cbd_pkg::in_t  in_data,
  output cbd_pkg::tok_t tok
);

  logic [7:0] b;

  assign b = in_data.data_byte;

  always_comb begin
    tok.data_byte  = b;
    tok.body_start = in_data.body_start;
    tok.cls        = cbd_pkg::CLS_OTHER;
    tok.hex_val    = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      tok.cls     = cbd_pkg::CLS_HEX;
      tok.hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      tok.cls     = cbd_pkg::CLS_HEX;
      tok.hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      tok.cls     = cbd_pkg::CLS_HEX;
      tok.hex_val = 4'(b - 8'h37);
    end else if (b == cbd_pkg::CHAR_CR) begin
      tok.cls = cbd_pkg::CLS_CR;
    end else if (b == cbd_pkg::CHAR_LF) begin
      tok.cls = cbd_pkg::CLS_LF;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbd_back.sv =====
`default_nettype none

module cbd_back #(
  parameter int LEN_BITS = cbd_pkg::LEN_BITS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           tok_valid,
  input  cbd_pkg::tok_t tok,
  output logic          tok_pop,
  input  wire           res_full,
  output logic          res_push,
  output cbd_pkg::out_t res
);

  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;

  logic [1:0]          phase_r, phase_nxt;
  logic [LEN_BITS-1:0] remaining_r, remaining_nxt;
  logic                digit_seen_r, digit_seen_nxt;
  logic                cr_seen_r, cr_seen_nxt;
  logic                stopped_r, stopped_nxt;

  // The back end takes a token only when a result slot is guaranteed free.
  assign tok_pop = tok_valid && !res_full;

  always_comb begin
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    digit_seen_nxt = digit_seen_r;
    cr_seen_nxt    = cr_seen_r;
    stopped_nxt    = stopped_r;
    res_push       = 1'b0;
    res.out_byte   = 8'd0;
    res.out_kind   = cbd_pkg::KIND_PAYLOAD;
    if (tok_pop) begin
      if (tok.body_start) begin
        phase_nxt      = PH_SIZE;
        remaining_nxt  = '0;
        digit_seen_nxt = 1'b0;
        cr_seen_nxt    = 1'b0;
        stopped_nxt    = 1'b0;
      end
      if (!stopped_nxt) begin
        unique case (phase_nxt)
          PH_DATA: begin
            remaining_nxt = remaining_nxt - 1'b1;
            if (remaining_nxt == '0) begin
              phase_nxt = PH_SKIP;
            end
            res_push     = 1'b1;
            res.out_byte = tok.data_byte;
            res.out_kind = cbd_pkg::KIND_PAYLOAD;
          end
          PH_SIZE: begin
            case (tok.cls)
              cbd_pkg::CLS_CR: begin
                if (cr_seen_nxt) begin
                  stopped_nxt  = 1'b1;
                  res_push     = 1'b1;
                  res.out_kind = cbd_pkg::KIND_ERROR;
                end else begin
                  cr_seen_nxt = 1'b1;
                end
              end
              cbd_pkg::CLS_LF: begin
                if (!digit_seen_nxt) begin
                  stopped_nxt  = 1'b1;
                  res_push     = 1'b1;
                  res.out_kind = cbd_pkg::KIND_ERROR;
                end else begin
                  digit_seen_nxt = 1'b0;
                  cr_seen_nxt    = 1'b0;
                  if (remaining_nxt == '0) begin
                    stopped_nxt  = 1'b1;
                    res_push     = 1'b1;
                    res.out_kind = cbd_pkg::KIND_DONE;
                  end else begin
                    phase_nxt = PH_DATA;
                  end
                end
              end
              cbd_pkg::CLS_HEX: begin
                // A digit after CR, or one that would shift bits out of the top, is an error.
                if (cr_seen_nxt || (remaining_nxt[LEN_BITS-1 -: 4] != 4'd0)) begin
                  stopped_nxt  = 1'b1;
                  res_push     = 1'b1;
                  res.out_kind = cbd_pkg::KIND_ERROR;
                end else begin
                  remaining_nxt  = {remaining_nxt[LEN_BITS-5:0], tok.hex_val};
                  digit_seen_nxt = 1'b1;
                end
              end
              default: begin
                stopped_nxt  = 1'b1;
                res_push     = 1'b1;
                res.out_kind = cbd_pkg::KIND_ERROR;
              end
            endcase
          end
          default: begin
            // Skipping to the end of the line after a payload.
            if (tok.cls == cbd_pkg::CLS_LF) begin
              phase_nxt      = PH_SIZE;
              remaining_nxt  = '0;
              digit_seen_nxt = 1'b0;
              cr_seen_nxt    = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      remaining_r  <= '0;
      digit_seen_r <= 1'b0;
      cr_seen_r    <= 1'b0;
      stopped_r    <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      digit_seen_r <= digit_seen_nxt;
      cr_seen_r    <= cr_seen_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/chunked_body_decoder.sv =====
// Chunked body decoder: takes one byte of an HTTP chunked body per cycle and
// returns payload bytes, one completion result when a size line of value zero
// ends the body, or one error result on a malformed size line; after either,
// bytes are ignored until a byte marked body_start opens a new body. Both sides
// behave as queues: a byte is taken whenever in_full is low, one byte per cycle
// sustained; a byte waits in the token queue and its result in the result queue.
// The rate is set by the back-end state update, which handles one classified
// byte per cycle; a four-entry queue between byte classification and the state
// update and a two-entry result queue let either side stall without loss.
`default_nettype none

module chunked_body_decoder #(
  parameter int LEN_BITS = cbd_pkg::LEN_BITS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_push,
  input  cbd_pkg::in_t  in_data,
  output logic          in_full,
  input  wire           out_pop,
  output cbd_pkg::out_t out_data,
  output logic          out_empty
);

  cbd_pkg::tok_t tok_in;
  cbd_pkg::tok_t tok_out;
  logic          tok_empty;
  logic          tok_pop;
  cbd_pkg::out_t res;
  logic          res_push;
  logic          res_full;

  cbd_front u_front (
    .in_data (in_data),
    .tok     (tok_in)
  );

  cbd_fifo #(
    .item_t (cbd_pkg::tok_t),
    .DEPTH  (cbd_pkg::TOKEN_DEPTH)
  ) u_tok_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (tok_in),
    .full    (in_full),
    .pop     (tok_pop),
    .rd_data (tok_out),
    .empty   (tok_empty)
  );

  cbd_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (!tok_empty),
    .tok       (tok_out),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  cbd_fifo #(
    .item_t (cbd_pkg::out_t),
    .DEPTH  (cbd_pkg::RESULT_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cbd_checker.sv =====
`default_nettype none
`include "chunked_body_decoder_macros.svh"

module cbd_checker (
  input wire           clk,
  input wire           rst_n,
  input wire           in_full,
  input wire           out_pop,
  input cbd_pkg::out_t out_data,
  input wire           out_empty
);

  logic is_payload;
  logic byte_clear;
  logic waiting;

  assign is_payload = (out_data.out_kind == cbd_pkg::KIND_PAYLOAD);
  assign byte_clear = (out_data.out_byte == 8'd0);
  assign waiting    = !out_empty && !out_pop;

  `CBD_ASSERT(a_kind_legal, out_empty || (out_data.out_kind <= cbd_pkg::KIND_ERROR), "bad kind")

  `CBD_ASSERT(a_byte_zero, out_empty || is_payload || byte_clear, "byte on non-payload")

  `CBD_ASSERT(a_hold, $past(rst_n && waiting) |-> !out_empty && $stable(out_data), "result moved")

  `CBD_ASSERT_AFTER_RESET(a_reset_state, !in_full && out_empty, "queues not empty after reset")

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (.*);

`default_nettype wire

// ===== dv/chunked_body_decoder_tb.sv =====
`timescale 1ns / 100ps

module chunked_body_decoder_tb;

  localparam int ITEMS       = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 50;
  localparam int LEN_BITS    = cbd_pkg::LEN_BITS_DEF;

  typedef enum logic [1:0] {ST_SIZE, ST_DATA, ST_SKIP} line_state_t;
  // A directed row is either checked by the predictor or carries its typed-in result.
  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, GIVES_DONE, GIVES_ERROR} check_t;

  typedef struct {
    cbd_pkg::in_t item;
    check_t       how;
  } dir_row_t;

  logic          clk;
  logic          rst_n   = 1'b0;
  logic          in_push = 1'b0;
  cbd_pkg::in_t  in_data = '0;
  logic          in_full;
  logic          out_pop = 1'b0;
  cbd_pkg::out_t out_data;
  logic          out_empty;

  chunked_body_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_data (out_data),
    .out_empty(out_empty)
  );

  // Decoder state as predicted.
  line_state_t         line_state;
  logic [LEN_BITS-1:0] chunk_left;
  logic                digit_seen;
  logic                cr_seen;
  logic                body_stopped;

  cbd_pkg::out_t expected_results[$];
  cbd_pkg::in_t  pending_bytes[$];
  dir_row_t      directed_rows[$];
  cbd_pkg::out_t want;
  bit            mark_start;
  bit            quiet;
  int            stall_left;
  int            n_sent, n_decoded, n_payload, n_done, n_error;
  int            failures, cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_decoder();
    line_state   = ST_SIZE;
    chunk_left   = '0;
    digit_seen   = 1'b0;
    cr_seen      = 1'b0;
    body_stopped = 1'b0;
  endfunction

  function automatic bit size_error(output cbd_pkg::out_t res);
    body_stopped = 1'b1;
    res = cbd_pkg::out_t'{8'h00, cbd_pkg::KIND_ERROR};
    return 1'b1;
  endfunction

  // Returns 1 when the byte yields a result; live is 0 for a byte that is ignored.
  function automatic bit predict_result(input cbd_pkg::in_t item, output cbd_pkg::out_t res,
                                        output bit live);
    logic [7:0] b;
    int         nib;
    b = item.data_byte;
    res = '0;
    if (item.body_start) clear_decoder();
    live = !body_stopped;
    if (body_stopped) return 1'b0;

    if (line_state == ST_DATA) begin
      chunk_left = chunk_left - 1'b1;
      if (chunk_left == '0) line_state = ST_SKIP;
      res = cbd_pkg::out_t'{b, cbd_pkg::KIND_PAYLOAD};
      return 1'b1;
    end
    if (line_state != ST_SIZE) begin
      if (b == cbd_pkg::CHAR_LF) clear_decoder();
      return 1'b0;
    end

    if (b == cbd_pkg::CHAR_CR) begin
      if (cr_seen) return size_error(res);
      cr_seen = 1'b1;
      return 1'b0;
    end
    if (b == cbd_pkg::CHAR_LF) begin
      if (!digit_seen) return size_error(res);
      digit_seen = 1'b0;
      cr_seen    = 1'b0;
      if (chunk_left == '0) begin
        body_stopped = 1'b1;
        res = cbd_pkg::out_t'{8'h00, cbd_pkg::KIND_DONE};
        return 1'b1;
      end
      line_state = ST_DATA;
      return 1'b0;
    end
    if (b >= "0" && b <= "9") nib = b - "0";
    else if (b >= "a" && b <= "f") nib = b - "a" + 10;
    else if (b >= "A" && b <= "F") nib = b - "A" + 10;
    else nib = -1;
    if (nib < 0 || cr_seen || chunk_left[LEN_BITS-1 -: 4] != 4'h0) return size_error(res);
    chunk_left = {chunk_left[LEN_BITS-5:0], 4'(nib)};
    digit_seen = 1'b1;
    return 1'b0;
  endfunction

  function automatic void dir_row(input logic [7:0] b, input bit start, input check_t how);
    directed_rows.push_back('{item: cbd_pkg::in_t'{b, start}, how: how});
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    return (($urandom_range(1) == 0) ? "a" : "A") + 8'(nib) - 8'd10;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    pending_bytes.push_back(cbd_pkg::in_t'{b, mark_start});
    mark_start = 1'b0;
  endfunction

  function automatic void put_size(input logic [31:0] size);
    int n_digits;
    n_digits = 1;
    while (n_digits < 8 && (size >> (4 * n_digits)) != 0) n_digits++;
    repeat ($urandom_range(0, 2)) put_byte(hex_char(4'h0));
    for (int i = n_digits - 1; i >= 0; i--) put_byte(hex_char(size[4 * i +: 4]));
    if ($urandom_range(3) != 0) put_byte(cbd_pkg::CHAR_CR);
    put_byte(cbd_pkg::CHAR_LF);
  endfunction

  function automatic void put_chunk_end();
    logic [7:0] junk;
    case ($urandom_range(0, 3))
      0: put_byte(cbd_pkg::CHAR_LF);
      1: begin
        // Junk before the LF is skipped; an LF inside it would end the skip early.
        repeat ($urandom_range(1, 3)) begin
          junk = 8'($urandom_range(0, 255));
          put_byte((junk == cbd_pkg::CHAR_LF) ? cbd_pkg::CHAR_CR : junk);
        end
        put_byte(cbd_pkg::CHAR_LF);
      end
      default: begin
        put_byte(cbd_pkg::CHAR_CR);
        put_byte(cbd_pkg::CHAR_LF);
      end
    endcase
  endfunction

  // One body: a few well-formed chunks with random payload, then a clean end or a flaw.
  function automatic void build_body();
    int          n_chunks, len, flaw;
    logic [31:0] huge;
    mark_start = ($urandom_range(15) != 0);
    n_chunks = $urandom_range(0, 3);
    flaw = $urandom_range(0, 11);
    repeat (n_chunks) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      put_size(32'(len));
      repeat (len) put_byte(8'($urandom_range(0, 255)));
      put_chunk_end();
    end
    case (flaw)
      0: begin
        put_byte(hex_char(4'($urandom_range(1, 15))));
        put_byte(($urandom_range(1) == 0) ? ";" : 8'($urandom_range(0, 255)));
        put_byte(cbd_pkg::CHAR_LF);
      end
      1: begin
        if ($urandom_range(1) == 0) put_byte(cbd_pkg::CHAR_CR);
        put_byte(cbd_pkg::CHAR_LF);
      end
      2: begin
        put_byte(hex_char(4'($urandom_range(0, 15))));
        put_byte(cbd_pkg::CHAR_CR);
        put_byte(cbd_pkg::CHAR_CR);
      end
      3: begin
        put_byte(hex_char(4'($urandom_range(0, 15))));
        put_byte(cbd_pkg::CHAR_CR);
        put_byte(hex_char(4'($urandom_range(0, 15))));
      end
      4: begin
        // Nine significant digits cannot fit the counter.
        put_byte(hex_char(4'($urandom_range(1, 15))));
        repeat (8) put_byte(hex_char(4'($urandom_range(0, 15))));
      end
      5: begin
        // A huge chunk that the next body's start marker cuts short.
        huge = $urandom();
        put_size(huge);
        repeat ($urandom_range(0, 20)) put_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        put_size(32'h0);
        if (flaw == 6) repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  task automatic send_byte(input cbd_pkg::in_t item, input check_t how);
    cbd_pkg::out_t res;
    bit            has_res;
    bit            live;
    if (!quiet && $urandom_range(4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    n_sent++;
    has_res = predict_result(item, res, live);
    if (live) n_decoded++;
    quiet = (n_decoded >= ITEMS - ITEMS / 8);
    case (how)
      BY_MODEL:    if (has_res) expected_results.push_back(res);
      GIVES_DONE:  expected_results.push_back(cbd_pkg::out_t'{8'h00, cbd_pkg::KIND_DONE});
      GIVES_ERROR: expected_results.push_back(cbd_pkg::out_t'{8'h00, cbd_pkg::KIND_ERROR});
      default: ;
    endcase
  endtask

  // Result side: pops with random stall bursts and checks each transaction in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        case (out_data.out_kind)
          cbd_pkg::KIND_PAYLOAD: n_payload++;
          cbd_pkg::KIND_DONE:    n_done++;
          default:               n_error++;
        endcase
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $error("out_data: expected no result, actual kind %0d byte 0x%02h",
                   out_data.out_kind, out_data.out_byte);
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_kind !== want.out_kind) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $error("out_kind: expected %0d, actual %0d", want.out_kind, out_data.out_kind);
          end
          if (out_data.out_byte !== want.out_byte) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $error("out_byte: expected 0x%02h, actual 0x%02h", want.out_byte,
                     out_data.out_byte);
          end
        end
      end
      if (stall_left == 0 && !quiet && $urandom_range(4) == 0) stall_left = $urandom_range(1, 4);
      if (stall_left != 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results still outstanding.", cycle_count,
               expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clear_decoder();

    dir_row("0",              1'b1, NO_RESULT);    // zero size ends the body
    dir_row(cbd_pkg::CHAR_LF, 1'b0, GIVES_DONE);
    dir_row("x",              1'b0, NO_RESULT);    // ignored once the body has ended
    dir_row("2",              1'b1, NO_RESULT);
    dir_row(cbd_pkg::CHAR_CR, 1'b0, NO_RESULT);
    dir_row(cbd_pkg::CHAR_LF, 1'b0, NO_RESULT);
    dir_row(8'h00,            1'b0, BY_MODEL);
    dir_row(8'hFF,            1'b0, BY_MODEL);
    dir_row(cbd_pkg::CHAR_LF, 1'b0, NO_RESULT);
    dir_row("0",              1'b0, NO_RESULT);    // a zero value written as two digits
    dir_row("0",              1'b0, NO_RESULT);
    dir_row(cbd_pkg::CHAR_LF, 1'b0, GIVES_DONE);
    dir_row("g",              1'b1, GIVES_ERROR);  // not a hex digit
    dir_row(cbd_pkg::CHAR_LF, 1'b1, GIVES_ERROR);  // size line with no digits
    dir_row(cbd_pkg::CHAR_CR, 1'b1, NO_RESULT);
    dir_row(cbd_pkg::CHAR_CR, 1'b0, GIVES_ERROR);  // second CR
    dir_row("a",              1'b1, NO_RESULT);
    dir_row(cbd_pkg::CHAR_CR, 1'b0, NO_RESULT);
    dir_row("B",              1'b0, GIVES_ERROR);  // digit after the CR
    dir_row("f",              1'b1, NO_RESULT);    // eight digits fill the counter
    dir_row("F",              1'b0, NO_RESULT);
    dir_row("f",              1'b0, NO_RESULT);
    dir_row("F",              1'b0, NO_RESULT);
    dir_row("f",              1'b0, NO_RESULT);
    dir_row("F",              1'b0, NO_RESULT);
    dir_row("f",              1'b0, NO_RESULT);
    dir_row("F",              1'b0, NO_RESULT);
    dir_row("1",              1'b0, GIVES_ERROR);  // the ninth digit overflows

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_byte(directed_rows[i].item, directed_rows[i].how);
    while (n_decoded < ITEMS) begin
      build_body();
      while (pending_bytes.size() != 0) send_byte(pending_bytes.pop_front(), BY_MODEL);
    end
    in_push <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d body bytes, %0d of them decoded, over well-formed and broken bodies.",
             n_sent, n_decoded);
    $display("Checked %0d payload bytes, %0d body completions and %0d format errors.",
             n_payload, n_done, n_error);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cbd_pkg.sv
rtl/core/cbd_fifo.sv
rtl/core/cbd_front.sv
rtl/core/cbd_back.sv
rtl/core/chunked_body_decoder.sv
rtl/core/cbd_checker.sv
dv/chunked_body_decoder_tb.sv
